>>> rtl/core/swmf_pkg.sv
// shared constants, configuration register indexes and the tally control struct
// for the sliding window mode filter; no dependencies
package swmf_pkg;

  localparam int MAX_WINDOW_DEF  = 32;
  localparam int NUM_CLASSES_DEF = 16;

  localparam int LABEL_W    = 4;
  localparam int WLEN_W     = 6;
  localparam int CLASS_W    = 4;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_WINDOW_LEN = 1'b0;
  localparam cfg_idx_t REG_BACKGROUND = 1'b1;

  localparam logic [WLEN_W-1:0]  WINDOW_LEN_RESET = 6'd30;
  localparam logic [CLASS_W-1:0] BACKGROUND_RESET = 4'd0;

  typedef struct packed {
    logic               clear;
    logic               valid;
    logic [LABEL_W-1:0] label;
  } tally_ctrl_t;

endpackage

>>> rtl/core/swmf_ifs.sv
// valid/ready channel interfaces for frame beats and result beats
// depends on swmf_pkg
interface swmf_frame_if import swmf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] label;
  logic               seq_start;
  logic               sample_anyway;

  modport source (output valid, label, seq_start, sample_anyway, input ready);
  modport sink   (input valid, label, seq_start, sample_anyway, output ready);
endinterface

interface swmf_result_if import swmf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               window_full;
  logic [LABEL_W-1:0] winner;
  logic               report;

  modport source (output valid, window_full, winner, report, input ready);
  modport sink   (input valid, window_full, winner, report, output ready);
endinterface

>>> rtl/core/swmf_tally.sv
// per-class vote counters with running maximum and winner tracking
// depends on swmf_pkg
module swmf_tally import swmf_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic               clk,
  input  tally_ctrl_t        ctrl,
  output logic [LABEL_W-1:0] winner
);

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  logic [CNT_W-1:0] counts [NUM_CLASSES];
  logic [CNT_W-1:0] best;
  logic [CLS_W-1:0] idx;
  logic [CNT_W-1:0] count_next;

  assign idx        = CLS_W'(ctrl.label);
  assign count_next = counts[idx] + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        counts[i] <= '0;
      end
      best   <= '0;
      winner <= '0;
    end else if (ctrl.valid) begin
      counts[idx] <= count_next;
      if (count_next > best) begin
        best   <= count_next;
        winner <= ctrl.label;
      end
    end
  end

endmodule

>>> rtl/core/sliding_window_mode_filter.sv
// Sliding window mode filter: keeps the most recent window_len labels in a ring memory and
// votes the most common one, ties going to the label that reached the top count first from
// oldest to newest. With n the effective window length (window_len held to 1..MAX_WINDOW),
// each frame beat first updates the ring; then, when the window is full, the n entries are
// scanned oldest first through the registered ring read port, one entry a cycle, while the
// scan is skipped as the window fills; finally the result register is loaded, waiting out
// any stall on the result side.
// A new frame is taken once the previous result sits in the output register.
// depends on swmf_pkg, swmf_ifs and swmf_tally
module sliding_window_mode_filter import swmf_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  swmf_frame_if.sink            frame,
  swmf_result_if.source         result,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int LW = $clog2(MAX_WINDOW + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    if (s >= (AW+1)'(MAX_WINDOW)) begin
      return AW'(s - (AW+1)'(MAX_WINDOW));
    end
    return AW'(s);
  endfunction

  state_t             state;
  logic [WLEN_W-1:0]  window_len;
  logic [CLASS_W-1:0] background;
  logic [LW-1:0]      fill_count;
  logic [AW-1:0]      oldest_slot;
  logic [LABEL_W-1:0] ring [MAX_WINDOW];
  logic [LABEL_W-1:0] rd_data;
  logic               rd_valid;
  logic [AW-1:0]      scan_ptr;
  logic [LW-1:0]      issued;
  logic               full_r;
  logic               sample_r;
  logic               out_valid;
  logic               out_full;
  logic [LABEL_W-1:0] out_winner;
  logic               out_report;

  logic [LW-1:0]      eff_len;
  logic [LABEL_W-1:0] lab_c;
  logic [LW-1:0]      fill_a, fill_b, fill_next;
  logic [AW-1:0]      oldest_a, oldest_b, oldest_next;
  logic [AW-1:0]      wr_addr;
  logic               vote;
  logic               accept;
  logic               issue;
  logic               load;
  logic [LABEL_W-1:0] tally_winner;
  tally_ctrl_t        tally_ctrl;

  assign accept = frame.valid && frame.ready;
  assign issue  = (state == S_SCAN) && (issued != fill_count);
  assign load   = (state == S_DONE) && (!out_valid || result.ready);

  assign frame.ready        = (state == S_IDLE) && !rst;
  assign result.valid       = out_valid;
  assign result.window_full = out_full;
  assign result.winner      = out_winner;
  assign result.report      = out_report;

  always_comb begin
    if (window_len == '0) begin
      eff_len = LW'(1);
    end else if (int'(window_len) > MAX_WINDOW) begin
      eff_len = LW'(MAX_WINDOW);
    end else begin
      eff_len = LW'(window_len);
    end
  end

  // frame update: clamp, clear, shrink, then shift the new label in
  always_comb begin
    if (int'(frame.label) >= NUM_CLASSES) begin
      lab_c = LABEL_W'(NUM_CLASSES - 1);
    end else begin
      lab_c = frame.label;
    end
    fill_a   = frame.seq_start ? '0 : fill_count;
    oldest_a = frame.seq_start ? '0 : oldest_slot;
    if (fill_a > eff_len) begin
      oldest_b = wrap({1'b0, oldest_a} + (AW+1)'(fill_a - eff_len));
      fill_b   = eff_len;
    end else begin
      oldest_b = oldest_a;
      fill_b   = fill_a;
    end
    wr_addr = wrap({1'b0, oldest_b} + (AW+1)'(fill_b));
    if (fill_b < eff_len) begin
      fill_next   = fill_b + LW'(1);
      oldest_next = oldest_b;
    end else begin
      fill_next   = fill_b;
      oldest_next = wrap({1'b0, oldest_b} + (AW+1)'(1));
    end
    vote = (fill_next == eff_len);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wr_addr] <= lab_c;
    end
    if (issue) begin
      rd_data <= ring[scan_ptr];
    end
  end

  assign tally_ctrl = '{clear: accept, valid: rd_valid, label: rd_data};

  swmf_tally #(
    .MAX_WINDOW  (MAX_WINDOW),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_tally (
    .clk    (clk),
    .ctrl   (tally_ctrl),
    .winner (tally_winner)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_LEN_RESET;
      background <= BACKGROUND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LEN: window_len <= cfg_data[WLEN_W-1:0];
        REG_BACKGROUND: background <= cfg_data[CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill_count  <= '0;
      oldest_slot <= '0;
      rd_valid    <= 1'b0;
    end else begin
      rd_valid <= issue;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fill_count  <= fill_next;
            oldest_slot <= oldest_next;
            state       <= vote ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (rd_valid && !issue) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      full_r   <= vote;
      sample_r <= frame.sample_anyway;
      scan_ptr <= oldest_next;
      issued   <= '0;
    end else if (issue) begin
      scan_ptr <= wrap({1'b0, scan_ptr} + (AW+1)'(1));
      issued   <= issued + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_full   <= full_r;
      out_winner <= full_r ? tally_winner : '0;
      out_report <= full_r && ((tally_winner != background) || sample_r);
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    int'(fill_count) <= MAX_WINDOW)
    else $error("fill count beyond ring depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issued <= fill_count))
    else $error("scan issued more reads than window entries");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> !rd_valid)
    else $error("ring read still in flight when result is loaded");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready) |=> (state != S_IDLE))
    else $error("frame beat accepted without starting work");
`endif

endmodule
